### design/mlsp_pkg.sv
// Package with the shared types and constants of the MPLS label stack parser.
package mlsp_pkg;

    localparam int LABEL_W = 20;
    localparam int TC_W = 3;
    localparam int TTL_W = 8;
    localparam int COUNT_W = 8;
    localparam int BYTES_W = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [BYTES_W-1:0] BYTES_MAX = 10'd1020;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_PAYLOAD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_LIMIT_ON = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DEPTH = 2'd2;

    localparam logic [LABEL_W-1:0] LABEL_IPV4_NULL = 20'd0;
    localparam logic [LABEL_W-1:0] LABEL_ROUTER_ALERT = 20'd1;
    localparam logic [LABEL_W-1:0] LABEL_IPV6_NULL = 20'd2;
    localparam logic [LABEL_W-1:0] LABEL_IMPLICIT_NULL = 20'd3;
    localparam logic [LABEL_W-1:0] LABEL_RSVD_LO = 20'd4;
    localparam logic [LABEL_W-1:0] LABEL_RSVD_HI = 20'd15;

    typedef enum logic [2:0] {
        ST_CONTINUE = 3'd0,
        ST_DONE = 3'd1,
        ST_TRUNC = 3'd2,
        ST_LABEL1 = 3'd3,
        ST_LABEL3 = 3'd4,
        ST_DEEP = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        WARN_NONE = 2'd0,
        WARN_LABEL0 = 2'd1,
        WARN_LABEL2 = 2'd2,
        WARN_RESERVED = 2'd3
    } t_warn;

    typedef enum logic [1:0] {
        PAY_NONE = 2'd0,
        PAY_IPV4 = 2'd1,
        PAY_IPV6 = 2'd2,
        PAY_ETHERNET = 2'd3
    } t_payload;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [TC_W-1:0] traffic_class;
        logic [TTL_W-1:0] hop_limit;
        logic bottom;
        logic missing;
        logic is_label3;
        logic is_label1_bottom;
        logic is_label0;
        logic is_label2;
        t_warn warn;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [TC_W-1:0] traffic_class;
        logic [TTL_W-1:0] hop_limit;
        logic bottom;
        t_status status;
        t_warn warn;
        t_payload payload;
        logic [BYTES_W-1:0] stack_bytes;
    } t_result;

endpackage

### design/mlsp_front.sv
// Front end: splits a header word into its fields and classifies its label.
module mlsp_front (
    input  logic [31:0] i_header_word,
    input  logic        i_word_missing,
    input  logic [1:0]  i_default_payload,
    output mlsp_pkg::t_item o_item
);

    logic [mlsp_pkg::LABEL_W-1:0] label;
    logic bos;

    assign label = i_header_word[31:12];
    assign bos = i_header_word[8];

    always_comb begin
        o_item = '0;
        o_item.missing = i_word_missing;
        o_item.warn = mlsp_pkg::WARN_NONE;
        if (!i_word_missing) begin
            o_item.label = label;
            o_item.traffic_class = i_header_word[11:9];
            o_item.hop_limit = i_header_word[7:0];
            o_item.bottom = bos;
            o_item.is_label3 = (label == mlsp_pkg::LABEL_IMPLICIT_NULL);
            o_item.is_label1_bottom = bos && (label == mlsp_pkg::LABEL_ROUTER_ALERT);
            o_item.is_label0 = (label == mlsp_pkg::LABEL_IPV4_NULL);
            o_item.is_label2 = (label == mlsp_pkg::LABEL_IPV6_NULL);
            if (bos && label == mlsp_pkg::LABEL_IPV4_NULL
                    && i_default_payload != mlsp_pkg::PAY_IPV4) begin
                o_item.warn = mlsp_pkg::WARN_LABEL0;
            end else if (bos && label == mlsp_pkg::LABEL_IPV6_NULL
                    && i_default_payload != mlsp_pkg::PAY_IPV6) begin
                o_item.warn = mlsp_pkg::WARN_LABEL2;
            end else if (label inside {[mlsp_pkg::LABEL_RSVD_LO:mlsp_pkg::LABEL_RSVD_HI]}) begin
                o_item.warn = mlsp_pkg::WARN_RESERVED;
            end
        end
    end

endmodule

### design/mlsp_queue.sv
// Two-entry queue of classified words between the front end and the back end.
module mlsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mlsp_pkg::t_item i_item,
    input  logic            i_pop,
    output mlsp_pkg::t_item o_item,
    output mlsp_pkg::t_queue_status o_status
);

    localparam int PTR_W = $clog2(mlsp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mlsp_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(mlsp_pkg::QUEUE_DEPTH);

    mlsp_pkg::t_item r_mem [mlsp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_item = r_mem[r_rd_ptr];
    assign o_status.full = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(mlsp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(mlsp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### design/mlsp_back.sv
// Back end: keeps the label count, decides the status and holds the result register.
module mlsp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mlsp_pkg::t_item i_item,
    input  logic            i_item_valid,
    output logic            o_pop,
    input  logic [1:0]      i_default_payload,
    input  logic            i_depth_limit_on,
    input  logic [7:0]      i_max_depth,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output mlsp_pkg::t_result o_result
);

    logic [mlsp_pkg::COUNT_W-1:0] r_seen, n_seen;
    logic r_out_valid, n_out_valid;
    mlsp_pkg::t_result r_result, n_result;

    assign o_pop = i_item_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_result = r_result;

    always_comb begin
        n_result = '0;
        n_result.status = mlsp_pkg::ST_CONTINUE;
        n_result.warn = mlsp_pkg::WARN_NONE;
        n_result.payload = mlsp_pkg::PAY_NONE;
        n_result.label = i_item.label;
        n_result.traffic_class = i_item.traffic_class;
        n_result.hop_limit = i_item.hop_limit;
        n_result.bottom = i_item.bottom;
        if (i_item.missing) begin
            n_result.status = mlsp_pkg::ST_TRUNC;
        end else if (i_item.is_label3) begin
            n_result.status = mlsp_pkg::ST_LABEL3;
        end else if (i_item.is_label1_bottom) begin
            n_result.status = mlsp_pkg::ST_LABEL1;
        end else begin
            n_result.warn = i_item.warn;
            if (i_depth_limit_on && r_seen >= i_max_depth) begin
                n_result.status = mlsp_pkg::ST_DEEP;
            end else if (i_item.bottom) begin
                n_result.status = mlsp_pkg::ST_DONE;
                if (i_item.is_label0) begin
                    n_result.payload = mlsp_pkg::PAY_IPV4;
                end else if (i_item.is_label2) begin
                    n_result.payload = mlsp_pkg::PAY_IPV6;
                end else begin
                    n_result.payload = mlsp_pkg::t_payload'(i_default_payload);
                end
                if (r_seen == mlsp_pkg::COUNT_MAX) begin
                    n_result.stack_bytes = mlsp_pkg::BYTES_MAX;
                end else begin
                    n_result.stack_bytes = {r_seen + 1'b1, 2'b00};
                end
            end
        end
    end

    always_comb begin
        n_seen = r_seen;
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
            if (n_result.status == mlsp_pkg::ST_CONTINUE) begin
                if (r_seen != mlsp_pkg::COUNT_MAX) begin
                    n_seen = r_seen + 1'b1;
                end
            end else begin
                n_seen = '0;
            end
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

### design/mpls_label_stack_parser.sv
// Top level of the MPLS label stack parser: configuration registers and the three stages.
// An accepted word goes into the queue, then is popped into the back end result register.
// Throughput: one word per cycle unless stalled; the back end counts labels word by word.
// The two-entry queue takes front end words while the result is stalled, until it is full.
// Reset is synchronous and active low; it empties the queue, clears the label count
// and the result valid, and loads the register reset values.
module mpls_label_stack_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_header_word,
    input  logic        i_word_missing,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [19:0] o_label,
    output logic [2:0]  o_traffic_class,
    output logic [7:0]  o_hop_limit,
    output logic        o_bottom,
    output logic [2:0]  o_status,
    output logic [1:0]  o_warning,
    output logic [1:0]  o_payload_type,
    output logic [9:0]  o_stack_bytes
);

    logic [1:0] r_default_payload;
    logic r_depth_limit_on;
    logic [7:0] r_max_depth;

    mlsp_pkg::t_item front_item;
    mlsp_pkg::t_item head_item;
    mlsp_pkg::t_queue_status queue_status;
    mlsp_pkg::t_result result;
    logic push;
    logic pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_payload <= mlsp_pkg::PAY_IPV4;
            r_depth_limit_on <= 1'b0;
            r_max_depth <= 8'd254;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mlsp_pkg::CFG_DEFAULT_PAYLOAD: r_default_payload <= i_cfg_data[1:0];
                mlsp_pkg::CFG_DEPTH_LIMIT_ON: r_depth_limit_on <= i_cfg_data[0];
                mlsp_pkg::CFG_MAX_DEPTH: r_max_depth <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = queue_status.full;
    assign push = i_in_valid && !queue_status.full;

    mlsp_front u_front (
        .i_header_word     (i_header_word),
        .i_word_missing    (i_word_missing),
        .i_default_payload (r_default_payload),
        .o_item            (front_item)
    );

    mlsp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (queue_status)
    );

    mlsp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (head_item),
        .i_item_valid      (!queue_status.empty),
        .o_pop             (pop),
        .i_default_payload (r_default_payload),
        .i_depth_limit_on  (r_depth_limit_on),
        .i_max_depth       (r_max_depth),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_result          (result)
    );

    assign o_label = result.label;
    assign o_traffic_class = result.traffic_class;
    assign o_hop_limit = result.hop_limit;
    assign o_bottom = result.bottom;
    assign o_status = result.status;
    assign o_warning = result.warn;
    assign o_payload_type = result.payload;
    assign o_stack_bytes = result.stack_bytes;

endmodule

### design/mlsp_checker.sv
// Port-level checks on the MPLS label stack parser and the bind that attaches them.
module mlsp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [19:0] o_label,
    input  logic        o_bottom,
    input  logic [2:0]  o_status,
    input  logic [1:0]  o_warning,
    input  logic [1:0]  o_payload_type,
    input  logic [9:0]  o_stack_bytes
);

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Result word dropped while stalled.");

    a_trunc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == mlsp_pkg::ST_TRUNC |->
            o_label == '0 && o_bottom == 1'b0 && o_warning == mlsp_pkg::WARN_NONE)
        else $error("Truncated word carries header fields.");

    a_not_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != mlsp_pkg::ST_DONE |->
            o_payload_type == mlsp_pkg::PAY_NONE && o_stack_bytes == '0)
        else $error("Payload type or stack length given without a finished stack.");

    a_done_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == mlsp_pkg::ST_DONE |->
            o_bottom && o_stack_bytes != '0 && o_stack_bytes[1:0] == 2'b00)
        else $error("Finished stack without bottom word or with a bad length.");

    a_label3_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == mlsp_pkg::ST_LABEL3 |->
            o_label == mlsp_pkg::LABEL_IMPLICIT_NULL && o_warning == mlsp_pkg::WARN_NONE)
        else $error("Implicit null error reported for the wrong label.");

endmodule

bind mpls_label_stack_parser mlsp_checker u_mlsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_label        (o_label),
    .o_bottom       (o_bottom),
    .o_status       (o_status),
    .o_warning      (o_warning),
    .o_payload_type (o_payload_type),
    .o_stack_bytes  (o_stack_bytes)
);

### sim/mpls_label_stack_parser_tb.sv
// Self-checking testbench for the MPLS label stack parser, with its own result predictor.
`timescale 1ns / 100ps

module mpls_label_stack_parser_tb;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_header_word = '0;
    logic        i_word_missing = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [19:0] o_label;
    logic [2:0]  o_traffic_class;
    logic [7:0]  o_hop_limit;
    logic        o_bottom;
    logic [2:0]  o_status;
    logic [1:0]  o_warning;
    logic [1:0]  o_payload_type;
    logic [9:0]  o_stack_bytes;

    mpls_label_stack_parser uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_header_word(i_header_word),
        .i_word_missing(i_word_missing),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_label(o_label),
        .o_traffic_class(o_traffic_class),
        .o_hop_limit(o_hop_limit),
        .o_bottom(o_bottom),
        .o_status(o_status),
        .o_warning(o_warning),
        .o_payload_type(o_payload_type),
        .o_stack_bytes(o_stack_bytes)
    );

    mlsp_pkg::t_payload cfg_payload = mlsp_pkg::PAY_IPV4;
    logic             cfg_limit_on = 1'b0;
    logic [7:0]       cfg_max_depth = 8'd254;
    logic [7:0]       stack_count = '0;
    mlsp_pkg::t_result pending_results[$];
    bit               in_held = 1'b0;
    bit               send_idle = 1'b1;
    bit               recv_idle = 1'b1;
    int               recv_wait = 0;
    int               words_sent = 0;
    int               words_checked = 0;
    int               stacks_done = 0;
    int               stacks_deep = 0;
    int               settings_used = 1;
    int               mismatches = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [31:0] make_word(input logic [19:0] lab, input logic [2:0] tc,
                                              input logic bos, input logic [7:0] ttl);
        return {lab, tc, bos, ttl};
    endfunction

    // Works out the result word for one header word and advances or clears the label count.
    function automatic mlsp_pkg::t_result parse_word(input logic [31:0] w, input logic m);
        mlsp_pkg::t_result r;
        logic [19:0] lab;
        logic        bos;
        int          bytes;
        r = '0;
        if (m) begin
            stack_count = '0;
            r.status = mlsp_pkg::ST_TRUNC;
            return r;
        end
        lab = w[31:12];
        bos = w[8];
        r.label = lab;
        r.traffic_class = w[11:9];
        r.hop_limit = w[7:0];
        r.bottom = bos;
        r.status = mlsp_pkg::ST_CONTINUE;
        r.warn = mlsp_pkg::WARN_NONE;
        r.payload = mlsp_pkg::PAY_NONE;
        if (lab == mlsp_pkg::LABEL_IMPLICIT_NULL) begin
            r.status = mlsp_pkg::ST_LABEL3;
        end else if (lab == mlsp_pkg::LABEL_ROUTER_ALERT && bos) begin
            r.status = mlsp_pkg::ST_LABEL1;
        end else begin
            if (bos && lab == mlsp_pkg::LABEL_IPV4_NULL && cfg_payload != mlsp_pkg::PAY_IPV4) begin
                r.warn = mlsp_pkg::WARN_LABEL0;
            end else if (bos && lab == mlsp_pkg::LABEL_IPV6_NULL
                    && cfg_payload != mlsp_pkg::PAY_IPV6) begin
                r.warn = mlsp_pkg::WARN_LABEL2;
            end else if (lab >= mlsp_pkg::LABEL_RSVD_LO && lab <= mlsp_pkg::LABEL_RSVD_HI) begin
                r.warn = mlsp_pkg::WARN_RESERVED;
            end
            if (cfg_limit_on && stack_count >= cfg_max_depth) begin
                r.status = mlsp_pkg::ST_DEEP;
            end else if (bos) begin
                r.status = mlsp_pkg::ST_DONE;
                if (lab == mlsp_pkg::LABEL_IPV4_NULL) begin
                    r.payload = mlsp_pkg::PAY_IPV4;
                end else if (lab == mlsp_pkg::LABEL_IPV6_NULL) begin
                    r.payload = mlsp_pkg::PAY_IPV6;
                end else begin
                    r.payload = cfg_payload;
                end
                bytes = (int'(stack_count) + 1) * 4;
                r.stack_bytes = (bytes > int'(mlsp_pkg::BYTES_MAX)) ? mlsp_pkg::BYTES_MAX
                                                                     : bytes[9:0];
            end
        end
        if (r.status == mlsp_pkg::ST_CONTINUE) begin
            if (stack_count != mlsp_pkg::COUNT_MAX) begin
                stack_count = stack_count + 8'd1;
            end
        end else begin
            stack_count = '0;
        end
        return r;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        mlsp_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, label %0d status %0d",
                         $time, o_label, o_status);
            end else begin
                want = pending_results.pop_front();
                words_checked++;
                if (want.status == mlsp_pkg::ST_DONE) stacks_done++;
                if (want.status == mlsp_pkg::ST_DEEP) stacks_deep++;
                if (o_label !== want.label) begin
                    report_field("label", int'(want.label), int'(o_label));
                end
                if (o_traffic_class !== want.traffic_class) begin
                    report_field("traffic_class", int'(want.traffic_class),
                                 int'(o_traffic_class));
                end
                if (o_hop_limit !== want.hop_limit) begin
                    report_field("hop_limit", int'(want.hop_limit), int'(o_hop_limit));
                end
                if (o_bottom !== want.bottom) begin
                    report_field("bottom", int'(want.bottom), int'(o_bottom));
                end
                if (o_status !== want.status) begin
                    report_field("status", int'(want.status), int'(o_status));
                end
                if (o_warning !== want.warn) begin
                    report_field("warning", int'(want.warn), int'(o_warning));
                end
                if (o_payload_type !== want.payload) begin
                    report_field("payload_type", int'(want.payload), int'(o_payload_type));
                end
                if (o_stack_bytes !== want.stack_bytes) begin
                    report_field("stack_bytes", int'(want.stack_bytes), int'(o_stack_bytes));
                end
            end
            recv_wait = recv_idle ? $urandom_range(0, 12) : 0;
        end else if (recv_wait > 0) begin
            recv_wait--;
        end
        i_out_stall <= (recv_wait != 0);
    end

    task automatic idle_input();
        if (in_held) begin
            i_in_valid <= 1'b0;
            in_held = 1'b0;
        end
    endtask

    task automatic send_word(input logic [31:0] w, input logic m);
        int gap;
        gap = send_idle ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            idle_input();
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_header_word <= w;
        i_word_missing <= m;
        in_held = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(parse_word(w, m));
        words_sent++;
    endtask

    task automatic wait_drained();
        idle_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            mlsp_pkg::CFG_DEFAULT_PAYLOAD: cfg_payload = mlsp_pkg::t_payload'(data[1:0]);
            mlsp_pkg::CFG_DEPTH_LIMIT_ON: cfg_limit_on = data[0];
            mlsp_pkg::CFG_MAX_DEPTH: cfg_max_depth = data;
            default: ;
        endcase
    endtask

    task automatic set_payload(input logic [1:0] p);
        logic [7:0] d;
        d = 8'($urandom);
        d[1:0] = p;
        write_reg(mlsp_pkg::CFG_DEFAULT_PAYLOAD, d);
    endtask

    task automatic set_limit(input logic on, input logic [7:0] depth);
        logic [7:0] d;
        d = 8'($urandom);
        d[0] = on;
        write_reg(mlsp_pkg::CFG_DEPTH_LIMIT_ON, d);
        write_reg(mlsp_pkg::CFG_MAX_DEPTH, depth);
        settings_used++;
    endtask

    task automatic test_word_fields();
        send_word(make_word(20'hFFFFF, 3'd7, 1'b1, 8'hFF), 1'b0);
        send_word(make_word(mlsp_pkg::LABEL_IPV4_NULL, 3'd0, 1'b0, 8'h00), 1'b0);
        send_word(make_word(mlsp_pkg::LABEL_IPV4_NULL, 3'd3, 1'b1, 8'd64), 1'b0);
        send_word(make_word(20'h12345, 3'd5, 1'b0, 8'd1), 1'b0);
        send_word(make_word(mlsp_pkg::LABEL_IPV6_NULL, 3'd2, 1'b1, 8'd2), 1'b0);
        send_word(make_word(mlsp_pkg::LABEL_ROUTER_ALERT, 3'd0, 1'b0, 8'd9), 1'b0);
        send_word(make_word(mlsp_pkg::LABEL_ROUTER_ALERT, 3'd1, 1'b1, 8'd9), 1'b0);
        send_word(make_word(mlsp_pkg::LABEL_IMPLICIT_NULL, 3'd0, 1'b0, 8'd1), 1'b0);
        send_word(make_word(mlsp_pkg::LABEL_IMPLICIT_NULL, 3'd4, 1'b1, 8'd1), 1'b0);
        send_word(make_word(mlsp_pkg::LABEL_RSVD_LO, 3'd6, 1'b0, 8'h80), 1'b0);
        send_word(make_word(mlsp_pkg::LABEL_RSVD_HI, 3'd1, 1'b0, 8'h7F), 1'b0);
        send_word(make_word(20'd16, 3'd0, 1'b1, 8'd1), 1'b0);
        send_word(32'hFFFFFFFF, 1'b1);
        send_word(make_word(20'h80000, 3'd0, 1'b1, 8'd0), 1'b0);
    endtask

    task automatic test_payload_setting();
        logic [1:0] p;
        for (int k = 0; k < 3; k++) begin
            p = (k == 0) ? mlsp_pkg::PAY_IPV6 : (k == 1) ? mlsp_pkg::PAY_ETHERNET
                                                         : mlsp_pkg::PAY_NONE;
            set_payload(p);
            settings_used++;
            send_word(make_word(mlsp_pkg::LABEL_IPV4_NULL, 3'd0, 1'b1, 8'd10), 1'b0);
            send_word(make_word(mlsp_pkg::LABEL_IPV6_NULL, 3'd0, 1'b1, 8'd10), 1'b0);
            send_word(make_word(20'd100, 3'd0, 1'b1, 8'd10), 1'b0);
        end
        set_payload(mlsp_pkg::PAY_IPV4);
    endtask

    task automatic test_depth_limit();
        set_limit(1'b1, 8'd0);
        send_word(make_word(20'd5, 3'd2, 1'b1, 8'd3), 1'b0);
        set_limit(1'b1, 8'd2);
        send_word(make_word(20'd200, 3'd0, 1'b0, 8'd3), 1'b0);
        send_word(make_word(20'd201, 3'd0, 1'b0, 8'd3), 1'b0);
        send_word(make_word(mlsp_pkg::LABEL_IPV4_NULL, 3'd0, 1'b1, 8'd3), 1'b0);
    endtask

    task automatic test_long_stack();
        set_limit(1'b0, 8'd254);
        for (int k = 0; k < 300; k++) begin
            send_word(make_word(20'($urandom_range(16, 20'hFFFFF)), 3'($urandom), 1'b0,
                                8'($urandom)), 1'b0);
        end
        send_word(make_word(20'd77, 3'd0, 1'b1, 8'd1), 1'b0);
        set_limit(1'b1, 8'd255);
        for (int k = 0; k < 256; k++) begin
            send_word(make_word(20'($urandom_range(16, 20'hFFFFF)), 3'($urandom), k == 255,
                                8'($urandom)), 1'b0);
        end
    endtask

    function automatic logic [19:0] pick_label();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 20'($urandom_range(0, 15));
        if (r < 30) return 20'hFFFFF;
        return 20'($urandom);
    endfunction

    task automatic new_setting();
        logic [7:0] depth;
        case ($urandom_range(0, 9))
            0: depth = 8'd0;
            1: depth = 8'd255;
            2: depth = 8'd254;
            3: depth = 8'($urandom);
            default: depth = 8'($urandom_range(0, 8));
        endcase
        set_payload(2'($urandom_range(0, 3)));
        set_limit(1'($urandom_range(0, 1)), depth);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 8'($urandom));
        send_idle = ($urandom_range(0, 4) != 0);
        recv_idle = ($urandom_range(0, 4) != 0);
    endtask

    task automatic test_random_stacks(input int target);
        int stop_at, next_setting, kind, depth;
        stop_at = words_sent + target;
        next_setting = words_sent;
        while (words_sent < stop_at) begin
            if (words_sent >= next_setting) begin
                new_setting();
                next_setting = words_sent + $urandom_range(150, 300);
            end
            if ($urandom_range(0, 49) == 0) wait_drained();
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                depth = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40)
                                                      : $urandom_range(1, 6);
                for (int k = 0; k < depth; k++) begin
                    if ($urandom_range(0, 99) < 3) begin
                        send_word($urandom, 1'b1);
                        break;
                    end
                    send_word(make_word(pick_label(), 3'($urandom), k == depth - 1,
                                        8'($urandom)), 1'b0);
                end
            end else if (kind < 90) begin
                send_word($urandom, 1'b0);
            end else begin
                send_word($urandom, 1'b1);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_word_fields();
        test_payload_setting();
        test_depth_limit();
        test_long_stack();
        test_random_stacks(1950 - words_sent);
        wait_drained();
        repeat (5) @(posedge i_clk);
        $display("Sent %0d header words under %0d register settings; checked %0d results,",
                 words_sent, settings_used, words_checked);
        $display("of which %0d closed a stack and %0d were discarded as too deep.",
                 stacks_done, stacks_deep);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
